[hw/rtl/epms_pkg.sv]
// Shared types, codes and constants for the encoder PID motor speed block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package epms_pkg;

  // Default parameter values
  localparam int PULSES_PER_TURN_DEF = 5500;
  localparam int DUTY_FULL_DEF       = 1000;
  localparam int COUNT_BITS_DEF      = 16;

  // Fixed arithmetic constants
  localparam int SEC_PER_MIN = 60;
  localparam int RPM_MAX     = 1023;

  // Field widths
  localparam int ENC_W      = 16;
  localparam int RPM_W      = 10;
  localparam int DUTY_W     = 10;
  localparam int SP_W       = 12;
  localparam int GAIN_W     = 16;
  localparam int PULSE_W    = 32;
  localparam int ERR_W      = 13;
  localparam int DERIV_W    = 14;
  localparam int SUM_W      = 32;
  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + SUM_W;
  localparam int PROD_D_W   = GAIN_W + DERIV_W;
  localparam int CSUM_W     = PROD_I_W + 2;
  localparam int CORR_W     = CSUM_W - 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Action codes of an input item
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd6;

  // Configuration reset values
  localparam logic [SP_W-1:0]          SETPOINT_RST = 12'd18;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST   = 16'sd2560;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST   = 16'sd128;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST   = 16'sd0;
  localparam logic [DUTY_W-1:0]        BASE_RST     = 10'd400;
  localparam logic [PULSE_W-1:0]       TARGET_RST   = 32'd27500;

  // Drive pin codes: bit 0 forward, bit 1 reverse
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b10;

  // What an item does once the front stage has looked at it
  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_START,
    KIND_STOP,
    KIND_RUN
  } kind_t;

  // Control that travels with every item down the pipeline
  typedef struct packed {
    kind_t      kind;
    logic       running;
    logic       finished;
    logic [1:0] dir;
  } ctl_t;

  // Item after the error stage
  typedef struct packed {
    ctl_t                       ctl;
    logic [RPM_W-1:0]           rpm;
    logic signed [ERR_W-1:0]    err;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DERIV_W-1:0]  deriv;
  } err_t;

  // Item after the gain products
  typedef struct packed {
    ctl_t                        ctl;
    logic [RPM_W-1:0]            rpm;
    logic signed [PROD_P_W-1:0]  prod_p;
    logic signed [PROD_I_W-1:0]  prod_i;
    logic signed [PROD_D_W-1:0]  prod_d;
  } prod_t;

  // Result item
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [RPM_W-1:0]  rpm;
    logic              running;
    logic              finished;
    logic              fwd;
    logic              rev;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/encoder_pid_motor_speed_tick.sv]
// Top level of the encoder PID motor speed block: input register, control
// registers and the stage chain. Depends on epms_pkg, epms_front, epms_speed, epms_pid.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_stall  | action, encoder_count
//   out      | out_valid / out_stall| duty, speed_rpm, running, finished,
//            |                      | drive_forward, drive_reverse
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per cycle while out_stall is low; each item passes an input register and
// five stages (front, rpm multiply, error, gain products, duty) before its result
// is shown. Each stage register moves on its own, so empty stages fill while a
// result waits under out_stall. Synchronous reset clears control and loop state at
// once; there is no clearing pass.
`default_nettype none

module encoder_pid_motor_speed_tick #(
  parameter int PULSES_PER_TURN = epms_pkg::PULSES_PER_TURN_DEF,
  parameter int DUTY_FULL       = epms_pkg::DUTY_FULL_DEF,
  parameter int COUNT_BITS      = epms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        action,
  input  wire logic [epms_pkg::ENC_W-1:0]        encoder_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [epms_pkg::DUTY_W-1:0]            duty,
  output logic [epms_pkg::RPM_W-1:0]             speed_rpm,
  output logic                                   running,
  output logic                                   finished,
  output logic                                   drive_forward,
  output logic                                   drive_reverse,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [epms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [epms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [63:0] RpmLim = 64'(epms_pkg::RPM_MAX + 1) * 64'(PULSES_PER_TURN);
  localparam int          NumW   = $clog2(RpmLim);

  // Control registers
  logic [epms_pkg::SP_W-1:0]          setpoint_rpm;
  logic signed [epms_pkg::GAIN_W-1:0] gain_p;
  logic signed [epms_pkg::GAIN_W-1:0] gain_i;
  logic signed [epms_pkg::GAIN_W-1:0] gain_d;
  logic [epms_pkg::DUTY_W-1:0]        base_duty;
  logic [epms_pkg::PULSE_W-1:0]       stop_pulses;
  logic                               reverse_dir;

  // Input register
  logic                               in_q_valid;
  logic [1:0]                         action_q;
  logic [epms_pkg::ENC_W-1:0]         count_q;
  logic [31:0]                        count_ext;
  logic                               in_ready;
  logic                               ld0;

  // Stage links
  logic                               front_ready;
  logic                               front_valid;
  epms_pkg::ctl_t                     front_ctl;
  logic [NumW-1:0]                    front_num;
  logic                               speed_ready;
  logic                               speed_valid;
  epms_pkg::err_t                     speed_item;
  logic                               pid_ready;
  epms_pkg::result_t                  res;

  // Write control registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_rpm <= epms_pkg::SETPOINT_RST;
      gain_p       <= epms_pkg::GAIN_P_RST;
      gain_i       <= epms_pkg::GAIN_I_RST;
      gain_d       <= epms_pkg::GAIN_D_RST;
      base_duty    <= epms_pkg::BASE_RST;
      stop_pulses  <= epms_pkg::TARGET_RST;
      reverse_dir  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epms_pkg::REG_SETPOINT: setpoint_rpm <= cfg_data[epms_pkg::SP_W-1:0];
        epms_pkg::REG_GAIN_P:   gain_p       <= cfg_data[epms_pkg::GAIN_W-1:0];
        epms_pkg::REG_GAIN_I:   gain_i       <= cfg_data[epms_pkg::GAIN_W-1:0];
        epms_pkg::REG_GAIN_D:   gain_d       <= cfg_data[epms_pkg::GAIN_W-1:0];
        epms_pkg::REG_BASE:     base_duty    <= cfg_data[epms_pkg::DUTY_W-1:0];
        epms_pkg::REG_TARGET:   stop_pulses  <= cfg_data[epms_pkg::PULSE_W-1:0];
        epms_pkg::REG_REVERSE:  reverse_dir  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Take an item into the input register
  assign in_ready = !in_q_valid || front_ready;
  assign in_stall = !in_ready;
  assign ld0      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (ld0) begin
      in_q_valid <= 1'b1;
    end else if (front_ready) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      action_q <= action;
      count_q  <= encoder_count;
    end
  end

  // Counter sample at the configured counter width
  assign count_ext = 32'(count_q);

  epms_front #(
    .PULSES_PER_TURN (PULSES_PER_TURN),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (in_q_valid),
    .up_ready    (front_ready),
    .up_action   (action_q),
    .up_count    (count_ext[COUNT_BITS-1:0]),
    .stop_pulses (stop_pulses),
    .reverse_dir (reverse_dir),
    .dn_valid    (front_valid),
    .dn_ready    (speed_ready),
    .dn_ctl      (front_ctl),
    .dn_num      (front_num)
  );

  epms_speed #(
    .PULSES_PER_TURN (PULSES_PER_TURN)
  ) u_speed (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (front_valid),
    .up_ready     (speed_ready),
    .up_ctl       (front_ctl),
    .up_num       (front_num),
    .setpoint_rpm (setpoint_rpm),
    .dn_valid     (speed_valid),
    .dn_ready     (pid_ready),
    .dn           (speed_item)
  );

  epms_pid #(
    .DUTY_FULL (DUTY_FULL)
  ) u_pid (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (speed_valid),
    .up_ready  (pid_ready),
    .up        (speed_item),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .base_duty (base_duty),
    .dn_valid  (out_valid),
    .dn_ready  (!out_stall),
    .dn        (res)
  );

  // Drive result ports
  assign duty          = res.duty;
  assign speed_rpm     = res.rpm;
  assign running       = res.running;
  assign finished      = res.finished;
  assign drive_forward = res.fwd;
  assign drive_reverse = res.rev;

  // A finished run leaves the loop halted with the duty dropped
  a_finish_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !running && duty == '0)
    else $error("finished item still running or driving duty");

  // Halted loop never drives the motor
  a_halt_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> duty == '0)
    else $error("duty nonzero while halted");

  // A running loop drives exactly one bridge input
  a_run_one_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && running |-> drive_forward != drive_reverse)
    else $error("running with no or both drive pins");

  // Both bridge inputs are never high together
  a_no_shoot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({drive_forward, drive_reverse}))
    else $error("both drive pins high");

endmodule

`default_nettype wire

[hw/rtl/epms_front.sv]
// Front stage: counter difference, pulse total, run state and rpm numerator.
// Depends on epms_pkg.
`default_nettype none

module epms_front #(
  parameter int PULSES_PER_TURN = epms_pkg::PULSES_PER_TURN_DEF,
  parameter int COUNT_BITS      = epms_pkg::COUNT_BITS_DEF,
  localparam logic [63:0] RpmLim = 64'(epms_pkg::RPM_MAX + 1) * 64'(PULSES_PER_TURN),
  localparam int NumW = $clog2(RpmLim)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          up_valid,
  output logic                               up_ready,
  input  wire logic [1:0]                    up_action,
  input  wire logic [COUNT_BITS-1:0]         up_count,
  input  wire logic [epms_pkg::PULSE_W-1:0]  stop_pulses,
  input  wire logic                          reverse_dir,
  output logic                               dn_valid,
  input  wire logic                          dn_ready,
  output epms_pkg::ctl_t                     dn_ctl,
  output logic [NumW-1:0]                    dn_num
);

  localparam int N60W = COUNT_BITS + 6;

  // Loop state
  logic [COUNT_BITS-1:0]        prev_count;
  logic [epms_pkg::PULSE_W-1:0] pulse_total;
  logic                         active;
  logic [1:0]                   dir;

  logic [COUNT_BITS-1:0]        prev_count_next;
  logic [epms_pkg::PULSE_W-1:0] pulse_total_next;
  logic                         active_next;
  logic [1:0]                   dir_next;

  epms_pkg::kind_t              kind;
  logic [COUNT_BITS-1:0]        raw;
  logic [COUNT_BITS-1:0]        mag;
  logic [epms_pkg::PULSE_W:0]   total_wide;
  logic [epms_pkg::PULSE_W-1:0] total_sat;
  logic                         fin;
  logic [N60W-1:0]              n60;
  logic [NumW-1:0]              num;
  logic                         ld;

  assign up_ready = !dn_valid || dn_ready;
  assign ld       = up_valid && up_ready;

  // Classify the item
  always_comb begin
    case (up_action)
      epms_pkg::ACT_START: kind = epms_pkg::KIND_START;
      epms_pkg::ACT_STOP:  kind = epms_pkg::KIND_STOP;
      epms_pkg::ACT_TICK:  kind = active ? epms_pkg::KIND_RUN : epms_pkg::KIND_IGNORE;
      default:             kind = epms_pkg::KIND_IGNORE;
    endcase
  end

  // Wrapped difference, magnitude and saturating pulse total
  assign raw        = up_count - prev_count;
  assign mag        = raw[COUNT_BITS-1] ? (~raw + 1'b1) : raw;
  assign total_wide = {1'b0, pulse_total} + (epms_pkg::PULSE_W + 1)'(mag);
  assign total_sat  = total_wide[epms_pkg::PULSE_W] ? '1 : total_wide[epms_pkg::PULSE_W-1:0];
  assign fin        = (kind == epms_pkg::KIND_RUN) && (total_sat >= stop_pulses);

  // Numerator of the rpm quotient; capping it below the limit caps rpm at its max
  assign n60 = {mag, 6'b0} - {4'b0, mag, 2'b0};
  assign num = (64'(n60) >= RpmLim) ? NumW'(RpmLim - 64'd1) : NumW'(n60);

  // Next loop state
  always_comb begin
    prev_count_next  = prev_count;
    pulse_total_next = pulse_total;
    active_next      = active;
    dir_next         = dir;
    case (kind)
      epms_pkg::KIND_START: begin
        prev_count_next  = '0;
        pulse_total_next = '0;
        active_next      = 1'b1;
        dir_next         = reverse_dir ? epms_pkg::DIR_REV : epms_pkg::DIR_FWD;
      end
      epms_pkg::KIND_STOP: begin
        active_next = 1'b0;
      end
      epms_pkg::KIND_RUN: begin
        prev_count_next  = up_count;
        pulse_total_next = total_sat;
        active_next      = !fin;
      end
      default: begin
      end
    endcase
  end

  // Update state as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count  <= '0;
      pulse_total <= '0;
      active      <= 1'b0;
      dir         <= epms_pkg::DIR_NONE;
    end else if (ld) begin
      prev_count  <= prev_count_next;
      pulse_total <= pulse_total_next;
      active      <= active_next;
      dir         <= dir_next;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ld) begin
      dn_valid <= 1'b1;
    end else if (dn_ready) begin
      dn_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      dn_ctl.kind     <= kind;
      dn_ctl.running  <= active_next;
      dn_ctl.finished <= fin;
      dn_ctl.dir      <= dir_next;
      dn_num          <= num;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/epms_speed.sv]
// Speed and error stages: rpm by reciprocal multiply, then error, saturating
// integral and derivative. Depends on epms_pkg.
`default_nettype none

module epms_speed #(
  parameter int PULSES_PER_TURN = epms_pkg::PULSES_PER_TURN_DEF,
  localparam logic [63:0] RpmLim = 64'(epms_pkg::RPM_MAX + 1) * 64'(PULSES_PER_TURN),
  localparam int NumW = $clog2(RpmLim)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire epms_pkg::ctl_t              up_ctl,
  input  wire logic [NumW-1:0]             up_num,
  input  wire logic [epms_pkg::SP_W-1:0]   setpoint_rpm,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output epms_pkg::err_t                   dn
);

  // floor(x / PULSES_PER_TURN) == (x * RecipM) >> RecipK for every x below 2**NumW
  localparam int          RecipK = NumW + $clog2(PULSES_PER_TURN);
  localparam logic [63:0] RecipM = ((64'd1 << RecipK) + 64'(PULSES_PER_TURN) - 64'd1)
                                   / 64'(PULSES_PER_TURN);
  localparam int          MW     = NumW + 2;
  localparam int          PW     = NumW + MW;

  localparam logic signed [epms_pkg::SUM_W-1:0] SumMax = {1'b0, {(epms_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [epms_pkg::SUM_W-1:0] SumMin = {1'b1, {(epms_pkg::SUM_W-1){1'b0}}};

  // Rpm stage
  logic [PW-1:0]                   rpm_prod;
  logic [epms_pkg::RPM_W-1:0]      rpm_meas;
  logic [epms_pkg::RPM_W-1:0]      held_rpm;
  logic [epms_pkg::RPM_W-1:0]      held_rpm_next;
  logic                            s2_valid;
  epms_pkg::ctl_t                  s2_ctl;
  logic [epms_pkg::RPM_W-1:0]      s2_rpm;
  logic                            s2_ready;
  logic                            ld2;

  // Error stage
  logic signed [epms_pkg::SUM_W-1:0]   error_sum;
  logic signed [epms_pkg::ERR_W-1:0]   last_err;
  logic signed [epms_pkg::SUM_W-1:0]   error_sum_next;
  logic signed [epms_pkg::ERR_W-1:0]   last_err_next;
  logic signed [epms_pkg::ERR_W-1:0]   err;
  logic signed [epms_pkg::SUM_W:0]     sum_wide;
  logic signed [epms_pkg::SUM_W-1:0]   sum_sat;
  logic signed [epms_pkg::DERIV_W-1:0] deriv;
  logic                                ld3;

  assign up_ready = s2_ready;
  assign s2_ready = !s2_valid || (!dn_valid || dn_ready);
  assign ld2      = up_valid && s2_ready;
  assign ld3      = s2_valid && (!dn_valid || dn_ready);

  // Speed from the capped numerator
  assign rpm_prod = PW'(up_num) * PW'(RecipM[MW-1:0]);
  assign rpm_meas = rpm_prod[RecipK +: epms_pkg::RPM_W];

  always_comb begin
    case (up_ctl.kind)
      epms_pkg::KIND_START: held_rpm_next = '0;
      epms_pkg::KIND_RUN:   held_rpm_next = rpm_meas;
      default:              held_rpm_next = held_rpm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_rpm <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (ld2) begin
        held_rpm <= held_rpm_next;
      end
      if (ld2) begin
        s2_valid <= 1'b1;
      end else if (ld3) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ctl <= up_ctl;
      s2_rpm <= held_rpm_next;
    end
  end

  // Error, saturating integral and derivative
  assign err      = $signed({1'b0, setpoint_rpm}) - $signed({3'b0, s2_rpm});
  assign sum_wide = (epms_pkg::SUM_W + 1)'(error_sum) + (epms_pkg::SUM_W + 1)'(err);
  assign deriv    = epms_pkg::DERIV_W'(err) - epms_pkg::DERIV_W'(last_err);

  always_comb begin
    if (sum_wide[epms_pkg::SUM_W] != sum_wide[epms_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[epms_pkg::SUM_W] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[epms_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    case (s2_ctl.kind)
      epms_pkg::KIND_START: begin
        error_sum_next = '0;
        last_err_next  = '0;
      end
      epms_pkg::KIND_RUN: begin
        error_sum_next = sum_sat;
        last_err_next  = err;
      end
      default: begin
        error_sum_next = error_sum;
        last_err_next  = last_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
      last_err  <= '0;
      dn_valid  <= 1'b0;
    end else begin
      if (ld3) begin
        error_sum <= error_sum_next;
        last_err  <= last_err_next;
      end
      if (ld3) begin
        dn_valid <= 1'b1;
      end else if (dn_ready) begin
        dn_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      dn.ctl   <= s2_ctl;
      dn.rpm   <= s2_rpm;
      dn.err   <= err;
      dn.sum   <= sum_sat;
      dn.deriv <= deriv;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/epms_pid.sv]
// Gain stage and duty stage: the three Q8.8 products, then the correction,
// base duty and clamp into the result register. Depends on epms_pkg.
`default_nettype none

module epms_pid #(
  parameter int DUTY_FULL = epms_pkg::DUTY_FULL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire epms_pkg::err_t                    up,
  input  wire logic signed [epms_pkg::GAIN_W-1:0] gain_p,
  input  wire logic signed [epms_pkg::GAIN_W-1:0] gain_i,
  input  wire logic signed [epms_pkg::GAIN_W-1:0] gain_d,
  input  wire logic [epms_pkg::DUTY_W-1:0]       base_duty,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready,
  output epms_pkg::result_t                      dn
);

  localparam int          ValW      = epms_pkg::CORR_W + 2;
  localparam logic [31:0] DutyFullW = 32'(DUTY_FULL);
  localparam logic [epms_pkg::DUTY_W-1:0] DutyFullLow = DutyFullW[epms_pkg::DUTY_W-1:0];

  logic                                  s4_valid;
  epms_pkg::prod_t                       s4;
  logic                                  s4_ready;
  logic                                  ld4;
  logic                                  ld5;

  logic signed [epms_pkg::CSUM_W-1:0]    csum;
  logic signed [epms_pkg::CSUM_W-1:0]    csum_adj;
  logic signed [epms_pkg::CORR_W-1:0]    corr;
  logic signed [ValW-1:0]                val;
  logic [epms_pkg::DUTY_W-1:0]           base_clamp;
  logic [epms_pkg::DUTY_W-1:0]           pid_clamp;
  logic [epms_pkg::DUTY_W-1:0]           duty_next;

  assign s4_ready = !s4_valid || (!dn_valid || dn_ready);
  assign up_ready = s4_ready;
  assign ld4      = up_valid && s4_ready;
  assign ld5      = s4_valid && (!dn_valid || dn_ready);

  // Gain products, one multiplier each
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (ld4) begin
      s4_valid <= 1'b1;
    end else if (ld5) begin
      s4_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4.ctl    <= up.ctl;
      s4.rpm    <= up.rpm;
      s4.prod_p <= epms_pkg::PROD_P_W'(gain_p) * epms_pkg::PROD_P_W'(up.err);
      s4.prod_i <= epms_pkg::PROD_I_W'(gain_i) * epms_pkg::PROD_I_W'(up.sum);
      s4.prod_d <= epms_pkg::PROD_D_W'(gain_d) * epms_pkg::PROD_D_W'(up.deriv);
    end
  end

  // Correction divided by 256, truncated toward zero
  assign csum     = epms_pkg::CSUM_W'(s4.prod_p) + epms_pkg::CSUM_W'(s4.prod_i)
                  + epms_pkg::CSUM_W'(s4.prod_d);
  assign csum_adj = csum + (csum[epms_pkg::CSUM_W-1] ? epms_pkg::CSUM_W'(255)
                                                      : epms_pkg::CSUM_W'(0));
  assign corr     = epms_pkg::CORR_W'(csum_adj >>> 8);
  assign val      = ValW'(corr) + ValW'($signed({1'b0, base_duty}));

  // Clamp to 0..DUTY_FULL
  assign base_clamp = (32'(base_duty) > DutyFullW) ? DutyFullLow : base_duty;

  always_comb begin
    if (val[ValW-1]) begin
      pid_clamp = '0;
    end else if (val > $signed(ValW'(DutyFullW))) begin
      pid_clamp = DutyFullLow;
    end else begin
      pid_clamp = val[epms_pkg::DUTY_W-1:0];
    end
  end

  // Pick the duty the item leaves behind
  always_comb begin
    case (s4.ctl.kind)
      epms_pkg::KIND_START: duty_next = base_clamp;
      epms_pkg::KIND_STOP:  duty_next = '0;
      epms_pkg::KIND_RUN:   duty_next = s4.ctl.finished ? '0 : pid_clamp;
      default:              duty_next = dn.duty;
    endcase
  end

  // Result register; its duty field is the held duty
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      dn       <= '0;
    end else begin
      if (ld5) begin
        dn_valid    <= 1'b1;
        dn.duty     <= duty_next;
        dn.rpm      <= s4.rpm;
        dn.running  <= s4.ctl.running;
        dn.finished <= s4.ctl.finished;
        dn.fwd      <= s4.ctl.dir[0];
        dn.rev      <= s4.ctl.dir[1];
      end else if (dn_ready) begin
        dn_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
